/* src/tksel_pkg.sv */
// ----------------------------------------------------------------------------
// Top-k score selector package
// Shared widths, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package tksel_pkg;

  localparam int IDX_W       = 10;  // zero-based feature index width
  localparam int IDX1_W      = 11;  // one-based index width on the result side
  localparam int SCORE_W     = 32;  // score width on the ports
  localparam int KEEP_W      = 6;   // keep_count register width
  localparam int Q_DEPTH     = 2;   // command queue depth
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  localparam int                MAX_KEEP_DEF     = 32;
  localparam int                MAX_FEATURES_DEF = 1024;
  localparam int                SCORE_BITS_DEF   = 32;
  localparam logic [KEEP_W-1:0] KEEP_RESET       = 6'd32;

  localparam logic OPERATION_OFFER = 1'b0;
  localparam logic OPERATION_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    CMD_PAIR,
    CMD_MAIN,
    CMD_DRAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX1_W-1:0] row1;
    logic [IDX1_W-1:0] col1;
  } cmd_t;

  typedef struct packed {
    logic [IDX1_W-1:0] row1;
    logic [IDX1_W-1:0] col1;
  } idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_REPLACE,
    CH_SHIFT
  } chain_op_t;

endpackage

/* src/tksel_if.sv */
// ----------------------------------------------------------------------------
// Top-k score selector channel interfaces
// Valid/ready channels for input items, result items and the keep_count write.
// ----------------------------------------------------------------------------
interface tksel_in_if;
  import tksel_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [IDX_W-1:0]   row_index;
  logic [IDX_W-1:0]   col_index;
  logic [SCORE_W-1:0] score;
  logic               is_main;

  modport source (output valid, operation, row_index, col_index, score, is_main,
                  input ready);
  modport sink   (input valid, operation, row_index, col_index, score, is_main,
                  output ready);
endinterface

interface tksel_out_if;
  import tksel_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX1_W-1:0]  row_out;
  logic [IDX1_W-1:0]  col_out;
  logic [SCORE_W-1:0] score_out;
  logic               last;

  modport source (output valid, row_out, col_out, score_out, last, input ready);
  modport sink   (input valid, row_out, col_out, score_out, last, output ready);
endinterface

interface tksel_cfg_if;
  import tksel_pkg::*;
  logic              valid;
  logic              ready;
  logic [KEEP_W-1:0] keep_count;

  modport source (output valid, keep_count, input ready);
  modport sink   (input valid, keep_count, output ready);
endinterface

/* src/tksel_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Top-k score selector command queue
// Short FIFO that decouples the accepting front from the selection chain.
// ----------------------------------------------------------------------------
module tksel_cmd_fifo #(
  parameter int SCORE_BITS = tksel_pkg::SCORE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tksel_pkg::cmd_t       push_cmd,
  input  logic [SCORE_BITS-1:0] push_score,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output tksel_pkg::cmd_t       head_cmd,
  output logic [SCORE_BITS-1:0] head_score
);
  import tksel_pkg::*;

  cmd_t                  cmd_mem   [Q_DEPTH];
  logic [SCORE_BITS-1:0] score_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty      = (cnt_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_cmd   = cmd_mem[rd_ptr_r];
  assign head_score = score_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wr_ptr_r]   <= push_cmd;
      score_mem[wr_ptr_r] <= push_score;
    end
  end

endmodule

/* src/tksel_front.sv */
// ----------------------------------------------------------------------------
// Top-k score selector front end
// Holds keep_count, accepts input transactions, filters and classifies them.
// ----------------------------------------------------------------------------
module tksel_front #(
  parameter int MAX_KEEP     = tksel_pkg::MAX_KEEP_DEF,
  parameter int MAX_FEATURES = tksel_pkg::MAX_FEATURES_DEF,
  parameter int SCORE_BITS   = tksel_pkg::SCORE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tksel_in_if.sink                       in_ch,
  tksel_cfg_if.sink                      cfg_ch,
  input  logic                           q_full,
  output logic                           push,
  output tksel_pkg::cmd_t                push_cmd,
  output logic [SCORE_BITS-1:0]          push_score,
  output logic [$clog2(MAX_KEEP+1)-1:0]  keep_eff
);
  import tksel_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  logic [KEEP_W-1:0] keep_count_r, keep_count_nxt;
  logic              accept;
  logic              col_ok, row_ok;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && !q_full;

  always_comb begin
    keep_count_nxt = cfg_ch.valid ? cfg_ch.keep_count : keep_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
    end else begin
      keep_count_r <= keep_count_nxt;
    end
  end

  // Zero acts as one; anything above the chain length acts as the chain length.
  always_comb begin
    if (keep_count_r == '0) begin
      keep_eff = CNT_W'(1);
    end else if (int'(keep_count_r) > MAX_KEEP) begin
      keep_eff = CNT_W'(MAX_KEEP);
    end else begin
      keep_eff = CNT_W'(keep_count_r);
    end
  end

  assign col_ok = int'(in_ch.col_index) < MAX_FEATURES;
  assign row_ok = in_ch.is_main || (int'(in_ch.row_index) < MAX_FEATURES);

  always_comb begin
    push_cmd.col1 = IDX1_W'(in_ch.col_index) + IDX1_W'(1);
    push_cmd.row1 = in_ch.is_main ? '0 : IDX1_W'(in_ch.row_index) + IDX1_W'(1);
    push_score    = SCORE_BITS'(in_ch.score);
    if (in_ch.operation == OPERATION_DRAIN) begin
      push_cmd.kind = CMD_DRAIN;
      push          = accept;
    end else begin
      push_cmd.kind = in_ch.is_main ? CMD_MAIN : CMD_PAIR;
      // Offers with an out-of-range index are accepted and dropped here.
      push          = accept && col_ok && row_ok;
    end
  end

endmodule

/* src/tksel_chain.sv */
// ----------------------------------------------------------------------------
// Top-k score selector chain
// Sorted shift-register chain that inserts, replaces the minimum and drains.
// ----------------------------------------------------------------------------
module tksel_chain #(
  parameter int MAX_KEEP   = tksel_pkg::MAX_KEEP_DEF,
  parameter int SCORE_BITS = tksel_pkg::SCORE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MAX_KEEP+1)-1:0]  keep_eff,
  input  logic                           q_empty,
  input  tksel_pkg::cmd_t                head_cmd,
  input  logic [SCORE_BITS-1:0]          head_score,
  output logic                           pop,
  tksel_out_if.source                    out_ch
);
  import tksel_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  idx_t                  idx_r     [MAX_KEEP];
  logic [SCORE_BITS-1:0] score_r   [MAX_KEEP];
  idx_t                  idx_nxt   [MAX_KEEP];
  logic [SCORE_BITS-1:0] score_nxt [MAX_KEEP];
  logic [MAX_KEEP-1:0]   after_pt;  // slot sits at or beyond the insertion point

  logic [CNT_W-1:0]  count_r, count_nxt;
  back_state_t       state_r, state_nxt;
  chain_op_t         op;
  idx_t              new_idx;
  logic              beats_min;
  logic              advance;

  logic               out_valid_r, out_valid_nxt;
  logic [IDX1_W-1:0]  row_out_r, col_out_r;
  logic [SCORE_W-1:0] score_out_r;
  logic               last_r;

  assign new_idx.row1 = head_cmd.row1;
  assign new_idx.col1 = head_cmd.col1;
  assign beats_min    = (count_r != '0) && (head_score > score_r[0]);
  assign pop          = (state_r == ST_IDLE) && !q_empty;
  assign advance      = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);

  // An equal score stays ahead of the new entry, which keeps ties in arrival order.
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_slot
    assign after_pt[i] = !(CNT_W'(i) < count_r) || (score_r[i] > head_score);

    always_comb begin
      idx_nxt[i]   = idx_r[i];
      score_nxt[i] = score_r[i];
      unique case (op)
        CH_INSERT: begin
          if (after_pt[i]) begin
            if (i > 0 && after_pt[(i > 0) ? i - 1 : 0]) begin
              idx_nxt[i]   = idx_r[(i > 0) ? i - 1 : 0];
              score_nxt[i] = score_r[(i > 0) ? i - 1 : 0];
            end else begin
              idx_nxt[i]   = new_idx;
              score_nxt[i] = head_score;
            end
          end
        end
        CH_REPLACE: begin
          if (!after_pt[i]) begin
            if (i < MAX_KEEP - 1 && !after_pt[(i < MAX_KEEP - 1) ? i + 1 : i]) begin
              idx_nxt[i]   = idx_r[(i < MAX_KEEP - 1) ? i + 1 : i];
              score_nxt[i] = score_r[(i < MAX_KEEP - 1) ? i + 1 : i];
            end else begin
              idx_nxt[i]   = new_idx;
              score_nxt[i] = head_score;
            end
          end
        end
        CH_SHIFT: begin
          if (i < MAX_KEEP - 1) begin
            idx_nxt[i]   = idx_r[(i < MAX_KEEP - 1) ? i + 1 : i];
            score_nxt[i] = score_r[(i < MAX_KEEP - 1) ? i + 1 : i];
          end
        end
        CH_HOLD: begin
        end
        default: begin
        end
      endcase
    end

    always_ff @(posedge clk) begin
      idx_r[i]   <= idx_nxt[i];
      score_r[i] <= score_nxt[i];
    end
  end

  always_comb begin
    op            = CH_HOLD;
    count_nxt     = count_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          unique case (head_cmd.kind)
            CMD_PAIR: begin
              if (count_r < keep_eff) begin
                op        = CH_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end else if (beats_min) begin
                op = CH_REPLACE;
              end
            end
            CMD_MAIN: begin
              if (beats_min) begin
                op = CH_REPLACE;
              end
            end
            CMD_DRAIN: begin
              if (count_r != '0) begin
                state_nxt = ST_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (advance) begin
          op            = CH_SHIFT;
          out_valid_nxt = 1'b1;
          count_nxt     = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row_out_r   <= idx_r[0].row1;
      col_out_r   <= idx_r[0].col1;
      score_out_r <= SCORE_W'(score_r[0]);
      last_r      <= (count_r == CNT_W'(1));
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_out   = row_out_r;
  assign out_ch.col_out   = col_out_r;
  assign out_ch.score_out = score_out_r;
  assign out_ch.last      = last_r;

endmodule

/* src/top_k_score_selector.sv */
// ----------------------------------------------------------------------------
// Top-k score selector
// Keeps the best-scoring index pairs of a stream and drains them in order.
// ----------------------------------------------------------------------------
// The block holds scored (row, column) pairs in a chain sorted by ascending
// score, adding a pair offer while fewer than keep_count are held. Offers are
// taken whenever the two-entry command queue has room; outside a drain the
// chain retires one queued offer per clock cycle, comparing the new score
// against every held entry at once. A drain shifts out one held entry each
// time the result side can take a transaction; offers behind it wait in the
// queue. An empty drain and an out-of-range offer produce no result. keep_count
// is written through its own channel; the user writes it only while the block
// is idle, which the block does not enforce. It takes effect for the next offer.
// ----------------------------------------------------------------------------
module top_k_score_selector #(
  parameter int MAX_KEEP     = tksel_pkg::MAX_KEEP_DEF,
  parameter int MAX_FEATURES = tksel_pkg::MAX_FEATURES_DEF,
  parameter int SCORE_BITS   = tksel_pkg::SCORE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tksel_in_if.sink     in_ch,
  tksel_cfg_if.sink    cfg_ch,
  tksel_out_if.source  out_ch
);
  import tksel_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  logic                  q_full, q_empty, push, pop;
  cmd_t                  push_cmd, head_cmd;
  logic [SCORE_BITS-1:0] push_score, head_score;
  logic [CNT_W-1:0]      keep_eff;

  tksel_front #(
    .MAX_KEEP     (MAX_KEEP),
    .MAX_FEATURES (MAX_FEATURES),
    .SCORE_BITS   (SCORE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_score (push_score),
    .keep_eff   (keep_eff)
  );

  tksel_cmd_fifo #(
    .SCORE_BITS (SCORE_BITS)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_score (push_score),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head_cmd   (head_cmd),
    .head_score (head_score)
  );

  tksel_chain #(
    .MAX_KEEP   (MAX_KEEP),
    .SCORE_BITS (SCORE_BITS)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .keep_eff   (keep_eff),
    .q_empty    (q_empty),
    .head_cmd   (head_cmd),
    .head_score (head_score),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

/* bench/tksel_result_checker.sv */
// ----------------------------------------------------------------------------
// Top-k score selector result checker
// Watches the input, keep_count and result channels, keeps its own sorted
// copy of the held entries and compares every drained result in order.
// ----------------------------------------------------------------------------
module tksel_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  tksel_in_if         in_ch,
  tksel_out_if        out_ch,
  tksel_cfg_if        cfg_ch,
  input  logic        end_check,
  output int          fail_count,
  output int          expected_left,
  output int          results_checked
);
  import tksel_pkg::*;

  typedef struct {
    logic [IDX1_W-1:0]  row1;
    logic [IDX1_W-1:0]  col1;
    logic [SCORE_W-1:0] score;
  } held_entry_t;

  typedef struct {
    logic [IDX1_W-1:0]  row_out;
    logic [IDX1_W-1:0]  col_out;
    logic [SCORE_W-1:0] score_out;
    logic               last;
  } drain_result_t;

  // Held entries, lowest score first; equal scores stay in arrival order.
  held_entry_t       held_chain[$];
  drain_result_t     drain_results_q[$];
  logic [KEEP_W-1:0] keep_reg;
  int                mismatches = 0;
  int                checked = 0;
  bit                end_done = 1'b0;

  assign fail_count      = mismatches;
  assign results_checked = checked;

  task automatic report(input string what);
    $display("tb mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int effective_keep();
    if (keep_reg == 0) return 1;
    if (keep_reg > MAX_KEEP_DEF) return MAX_KEEP_DEF;
    return int'(keep_reg);
  endfunction

  function automatic void insert_by_score(input held_entry_t e);
    int pos;
    pos = held_chain.size();
    while (pos > 0 && held_chain[pos-1].score > e.score) pos--;
    held_chain.insert(pos, e);
  endfunction

  function automatic void admit_offer(input logic main, input logic [IDX_W-1:0] row,
                                      input logic [IDX_W-1:0] col,
                                      input logic [SCORE_W-1:0] sc);
    held_entry_t e;
    if (col >= MAX_FEATURES_DEF) return;
    if (!main && row >= MAX_FEATURES_DEF) return;
    e.row1  = main ? '0 : {1'b0, row} + 1'b1;
    e.col1  = {1'b0, col} + 1'b1;
    e.score = sc;
    // A main effect never takes a free slot, it can only displace the minimum.
    if (!main && held_chain.size() < effective_keep()) begin
      insert_by_score(e);
    end else if (held_chain.size() > 0 && sc > held_chain[0].score) begin
      void'(held_chain.pop_front());
      insert_by_score(e);
    end
  endfunction

  function automatic void queue_drain();
    drain_result_t r;
    int n;
    n = held_chain.size();
    for (int i = 0; i < n; i++) begin
      r.row_out   = held_chain[i].row1;
      r.col_out   = held_chain[i].col1;
      r.score_out = held_chain[i].score;
      r.last      = (i == n - 1);
      drain_results_q.push_back(r);
    end
    held_chain.delete();
  endfunction

  task automatic check_result();
    drain_result_t want;
    if (drain_results_q.size() == 0) begin
      report($sformatf("unexpected result row %0d col %0d score %h",
                       out_ch.row_out, out_ch.col_out, out_ch.score_out));
      return;
    end
    want = drain_results_q.pop_front();
    checked++;
    if (out_ch.row_out !== want.row_out)
      report($sformatf("row_out %0d, expected %0d", out_ch.row_out, want.row_out));
    if (out_ch.col_out !== want.col_out)
      report($sformatf("col_out %0d, expected %0d", out_ch.col_out, want.col_out));
    if (out_ch.score_out !== want.score_out)
      report($sformatf("score_out %h, expected %h", out_ch.score_out, want.score_out));
    if (out_ch.last !== want.last)
      report($sformatf("last %b, expected %b", out_ch.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_chain.delete();
      drain_results_q.delete();
      keep_reg = KEEP_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) keep_reg = cfg_ch.keep_count;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OPERATION_DRAIN) begin
          queue_drain();
        end else begin
          admit_offer(in_ch.is_main, in_ch.row_index, in_ch.col_index, in_ch.score);
        end
      end
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (drain_results_q.size() != 0)
          report($sformatf("%0d expected results never arrived", drain_results_q.size()));
      end
    end
    expected_left = drain_results_q.size();
  end

endmodule

/* bench/tb_top_k_score_selector.sv */
// ----------------------------------------------------------------------------
// Top-k score selector testbench
// Drives directed and random offers and drains under four handshake phases,
// rewrites keep_count between phases and leaves checking to the checker.
// ----------------------------------------------------------------------------
module tb_top_k_score_selector;
  import tksel_pkg::*;

  localparam int RANDOM_PER_PHASE = 62;

  logic clk = 1'b0;
  logic rst_n;
  logic end_check;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   items_sent = 0;
  int   drains_sent = 0;
  int   keep_writes = 0;
  int   fail_count;
  int   expected_left;
  int   results_checked;

  tksel_in_if  in_ch ();
  tksel_out_if out_ch ();
  tksel_cfg_if cfg_ch ();

  top_k_score_selector u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  tksel_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .end_check       (end_check),
    .fail_count      (fail_count),
    .expected_left   (expected_left),
    .results_checked (results_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [SCORE_W-1:0] sc,
                           input logic main);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.row_index <= row;
    in_ch.col_index <= col;
    in_ch.score     <= sc;
    in_ch.is_main   <= main;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (op == OPERATION_DRAIN) drains_sent++;
  endtask

  task automatic offer_pair(input int row, input int col, input logic [SCORE_W-1:0] sc);
    send_item(OPERATION_OFFER, row[IDX_W-1:0], col[IDX_W-1:0], sc, 1'b0);
  endtask

  task automatic offer_main(input int row, input int col, input logic [SCORE_W-1:0] sc);
    send_item(OPERATION_OFFER, row[IDX_W-1:0], col[IDX_W-1:0], sc, 1'b1);
  endtask

  task automatic drain_store();
    send_item(OPERATION_DRAIN, IDX_W'($urandom), IDX_W'($urandom), $urandom,
              1'($urandom));
  endtask

  task automatic offer_random();
    logic [SCORE_W-1:0] sc;
    case ($urandom_range(4))
      0: sc = $urandom_range(15);
      1: sc = {16'($urandom_range(3)), 16'($urandom)};
      2: sc = ($urandom_range(1) == 1) ? '1 : '0;
      default: sc = $urandom;
    endcase
    send_item(OPERATION_OFFER, IDX_W'($urandom), IDX_W'($urandom), sc,
              ($urandom_range(4) == 0));
  endtask

  // The register may only change once the block has gone quiet, so the input
  // is parked and the last outstanding results are waited out first.
  task automatic write_keep(input logic [KEEP_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.keep_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    keep_writes++;
  endtask

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(6))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      4: return KEEP_W'($urandom_range(2, 8));
      default: return KEEP_W'($urandom_range(9, 40));
    endcase
  endfunction

  initial begin
    int burst_len;
    int phase_start;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OPERATION_OFFER;
    in_ch.row_index   <= '0;
    in_ch.col_index   <= '0;
    in_ch.score       <= '0;
    in_ch.is_main     <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.keep_count <= KEEP_RESET;
    end_check         <= 1'b0;
    rst_n             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset keep_count.
    drain_store();                       // nothing held yet
    offer_main(17, 5, 32'd100);          // main effect with an empty store
    offer_pair(0, 0, 32'h0);
    offer_pair(1023, 1023, 32'hFFFF_FFFF);
    offer_pair(3, 4, 32'd500);
    offer_pair(5, 6, 32'd500);
    offer_pair(7, 8, 32'd500);
    offer_main(1023, 1023, 32'h0);       // not strictly above the minimum
    offer_main(0, 9, 32'd1);             // displaces the minimum, store not full
    drain_store();

    // Two slots: a tie at the minimum is settled by arrival order.
    write_keep(6'd2);
    offer_pair(10, 11, 32'd7);
    offer_pair(12, 13, 32'd7);
    offer_pair(14, 15, 32'd7);
    offer_pair(16, 17, 32'd8);
    drain_store();

    // Zero behaves as one.
    write_keep(6'd0);
    offer_pair(20, 21, 32'd10);
    offer_pair(22, 23, 32'd20);
    offer_main(0, 24, 32'd30);
    drain_store();

    // Lowering keep_count below what is held keeps the surplus.
    write_keep(6'd63);
    offer_pair(30, 31, 32'h0001_0000);
    offer_pair(32, 33, 32'h0002_0000);
    offer_pair(34, 35, 32'h0003_0000);
    offer_pair(36, 37, 32'h0004_0000);
    write_keep(6'd1);
    offer_pair(38, 39, 32'h0005_0000);
    offer_pair(40, 41, 32'h0000_8000);
    drain_store();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      phase_start = items_sent;
      write_keep(pick_keep());
      while (items_sent - phase_start < RANDOM_PER_PHASE) begin
        if ($urandom_range(2) == 0) write_keep(pick_keep());
        burst_len = ($urandom_range(3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
        repeat ((burst_len + 1) / 2) offer_random();
        if ($urandom_range(3) == 0) write_keep(pick_keep());
        repeat (burst_len / 2) offer_random();
        // Now and then the store is left to carry over into the next burst.
        if ($urandom_range(5) != 0) drain_store();
      end
    end
    drain_store();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("tb: %0d items sent including %0d drains, %0d keep_count writes",
             items_sent, drains_sent, keep_writes);
    $display("tb: %0d drained entries compared across four handshake phases",
             results_checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
